[hdl/assert_macros.svh]
// Assertion macros used by the RTL of the haversine distance block.
// Bodies compile away when SYNTH is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

[hdl/hvd_pkg.sv]
// Types, fixed-point constants and the arctangent table of the haversine block.
// No dependencies; used by hvd_cordic and haversine_distance.
package hvd_pkg;

   localparam int LAT_W    = 30;
   localparam int LON_W    = 31;
   localparam int RAD_W    = 24;
   localparam int DIST_W   = 26;
   localparam int CSR_W    = 32;
   localparam int CORDIC_W = 34;

   localparam longint DEG2RAD_Q36     = 64'sd1199381129;
   localparam longint PI_Q30          = 64'sd3373259426;
   localparam longint TWO_PI_Q30      = 64'sd6746518852;
   localparam longint HALF_PI_Q30     = 64'sd1686629713;
   localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
   localparam longint ONE_Q30         = 64'sd1073741824;

   localparam logic [1:0] CSR_REF_LATITUDE  = 2'd0;
   localparam logic [1:0] CSR_REF_LONGITUDE = 2'd1;
   localparam logic [1:0] CSR_SPHERE_RADIUS = 2'd2;

   typedef logic signed [CORDIC_W-1:0] cordic_word_type;

   typedef struct packed {
      logic valid;
      logic flip;
   } cordic_ctl_type;

   localparam longint ATAN_HEAD [0:10] = '{
      64'sd843314857, 64'sd497837830, 64'sd263043837, 64'sd133525159,
      64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
      64'sd4194283, 64'sd2097149, 64'sd1048576
   };

   // atan(2^-i) in Q30; past the table the angle equals the shift itself
   function automatic cordic_word_type atan_entry(input int i);
      cordic_word_type r;
      if (i <= 10) begin
         r = cordic_word_type'(ATAN_HEAD[i]);
      end else if (i <= 30) begin
         r = cordic_word_type'(longint'(1) << (30 - i));
      end else begin
         r = '0;
      end
      return r;
   endfunction

endpackage

[hdl/haversine_distance.sv]
// Top level of the haversine great-circle distance pipeline.
// Depends on hvd_pkg, hvd_cordic and assert_macros.svh.
`include "assert_macros.svh"

// Haversine distance: each req item carries a point (latitude, longitude in
// degrees times 2^ANGLE_FRAC_BITS); the rsp item is the great-circle distance
// in whole meters, rounded to nearest, from the reference point held in the
// csr registers, on a sphere of radius sphere_radius. The block is a single
// pipeline that takes one item every cycle while req_ready is high and
// returns results in order. Between req accept and rsp_valid an item
// passes seven stages of degree-to-radian scaling and angle reduction,
// TRIG_ITERATIONS CORDIC rotation stages for sin/cos, five multiply and
// round stages for the haversine term, 31 stages of bit-serial square
// root (one result bit per stage, both roots side by side), TRIG_ITERATIONS
// CORDIC vectoring stages for atan2, three stages to scale by the radius,
// and the output register. A two-entry output buffer (output register plus
// skid) lets the pipeline keep taking items while a finished result waits;
// req_ready drops only once both entries are full, and the whole pipeline
// then holds in place. csr_ready is always high; write the registers only
// while no item is in flight. Index values past the register list are
// ignored.
module haversine_distance #(
   parameter int ANGLE_FRAC_BITS = 22,
   parameter int TRIG_ITERATIONS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [hvd_pkg::LAT_W-1:0]    req_point_latitude,
   input  logic signed [hvd_pkg::LON_W-1:0]    req_point_longitude,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [hvd_pkg::DIST_W-1:0]   rsp_distance_meters,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [1:0]                   csr_index,
   input  logic        [hvd_pkg::CSR_W-1:0]    csr_data
);
   import hvd_pkg::*;

   // scaled radians: |theta| < 2^(THETA_W-1) for any field bit pattern
   localparam int          THETA_W    = 58 - ANGLE_FRAC_BITS;
   localparam int          Q_W        = THETA_W - 30;
   localparam int unsigned HALF_SHIFT = 7 + ANGLE_FRAC_BITS;
   localparam int unsigned RAD_SHIFT  = 6 + ANGLE_FRAC_BITS;
   localparam int          SQRT_STEPS = 31;
   localparam longint      RECIP      = (longint'(1) << 44) / TWO_PI_Q30;

   localparam logic signed [31:0] D2R_C      = 32'(DEG2RAD_Q36);
   localparam logic        [11:0] RECIP_C    = 12'(RECIP);
   localparam logic        [32:0] TWO_PI_U   = 33'(TWO_PI_Q30);
   localparam cordic_word_type    TWO_PI_C   = cordic_word_type'(TWO_PI_Q30);
   localparam cordic_word_type    PI_C       = cordic_word_type'(PI_Q30);
   localparam cordic_word_type    HALF_PI_C  = cordic_word_type'(HALF_PI_Q30);
   localparam cordic_word_type    GAIN_C     = cordic_word_type'(CORDIC_GAIN_Q30);
   localparam logic signed [CORDIC_W:0] ONE_C = (CORDIC_W+1)'(ONE_Q30);

   // magnitude rounding: halves go away from zero
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] p,
                                                       input int unsigned s);
      logic [63:0] mag;
      logic [63:0] half;
      half = 64'd1 << (s - 1);
      mag  = p[63] ? 64'(-p) : 64'(p);
      mag  = (mag + half) >> s;
      return p[63] ? -$signed(mag) : $signed(mag);
   endfunction

   // ---------------------------------------------------------------- csr
   logic signed [LAT_W-1:0] ref_latitude_ff;
   logic signed [LON_W-1:0] ref_longitude_ff;
   logic        [RAD_W-1:0] sphere_radius_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_latitude_ff  <= '0;
         ref_longitude_ff <= '0;
         sphere_radius_ff <= RAD_W'(6371000);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REF_LATITUDE:  ref_latitude_ff  <= csr_data[LAT_W-1:0];
            CSR_REF_LONGITUDE: ref_longitude_ff <= csr_data[LON_W-1:0];
            CSR_SPHERE_RADIUS: sphere_radius_ff <= csr_data[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves together; it stops only when the skid entry is full
   logic advance;
   logic skid_valid_ff;

   assign advance   = !skid_valid_ff;
   assign req_ready = advance;

   // ---------------------------------------------------------------- S1: differences
   logic                    s1_valid_ff;
   logic signed [31:0]      s1_dlat_ff;
   logic signed [32:0]      s1_dlon_ff;
   logic signed [LAT_W-1:0] s1_lat2_ff;

   // ---------------------------------------------------------------- S2: to radians
   logic               s2_valid_ff;
   logic signed [63:0] s2_hlat_ff;
   logic signed [64:0] s2_hlon_ff;
   logic signed [61:0] s2_rlat1_ff;
   logic signed [61:0] s2_rlat2_ff;

   // lanes: 0 half dlat, 1 half dlon, 2 reference latitude, 3 point latitude
   logic                      s3_valid_ff;
   logic signed [THETA_W-1:0] s3_theta_ff [0:3];
   logic                      s4_valid_ff;
   logic        [THETA_W-1:0] s4_abs_ff   [0:3];
   logic                      s4_neg_ff   [0:3];
   logic        [Q_W-1:0]     s4_q_ff     [0:3];
   logic        [THETA_W-1:0] s4_abs_in   [0:3];
   logic        [Q_W-1:0]     s4_q_in     [0:3];
   logic                      s5_valid_ff;
   logic        [CORDIC_W-1:0] s5_rem_ff  [0:3];
   logic                      s5_neg_ff   [0:3];
   logic                      s6_valid_ff;
   cordic_word_type           s6_t_ff     [0:3];
   cordic_word_type           s6_t_in     [0:3];
   logic                      s7_valid_ff;
   cordic_word_type           s7_t_ff     [0:3];
   logic                      s7_flip_ff  [0:3];
   cordic_word_type           s7_t_in     [0:3];
   logic                      s7_flip_in  [0:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
      end
   end

   // reduction modulo 2*pi: estimate the quotient low, then correct once
   always_comb begin
      logic [THETA_W-21:0] hi;
      logic [THETA_W-9:0]  qprod;
      logic [CORDIC_W-1:0] rem;
      cordic_word_type     t;
      for (int l = 0; l < 4; l++) begin
         s4_abs_in[l] = s3_theta_ff[l][THETA_W-1] ? THETA_W'(-s3_theta_ff[l])
                                                  : THETA_W'(s3_theta_ff[l]);
         hi           = s4_abs_in[l][THETA_W-1:20];
         qprod        = hi * RECIP_C;
         s4_q_in[l]   = Q_W'(qprod >> 24);

         rem          = s5_rem_ff[l];
         if (rem >= CORDIC_W'(TWO_PI_U)) begin
            rem = rem - CORDIC_W'(TWO_PI_U);
         end
         s6_t_in[l]   = s5_neg_ff[l] ? -$signed(rem) : $signed(rem);

         // fold into [-pi, pi], then into [-pi/2, pi/2] with a sign flip
         t             = s6_t_ff[l];
         s7_flip_in[l] = 1'b0;
         if (t > PI_C) begin
            t = t - TWO_PI_C;
         end
         if (t < -PI_C) begin
            t = t + TWO_PI_C;
         end
         if (t > HALF_PI_C) begin
            t             = t - PI_C;
            s7_flip_in[l] = 1'b1;
         end else if (t < -HALF_PI_C) begin
            t             = t + PI_C;
            s7_flip_in[l] = 1'b1;
         end
         s7_t_in[l] = t;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_dlat_ff  <= 32'(req_point_latitude) - 32'(ref_latitude_ff);
         s1_dlon_ff  <= 33'(req_point_longitude) - 33'(ref_longitude_ff);
         s1_lat2_ff  <= req_point_latitude;

         s2_hlat_ff  <= s1_dlat_ff * D2R_C;
         s2_hlon_ff  <= s1_dlon_ff * 33'(D2R_C);
         s2_rlat1_ff <= 62'(ref_latitude_ff) * 62'(D2R_C);
         s2_rlat2_ff <= 62'(s1_lat2_ff) * 62'(D2R_C);

         s3_theta_ff[0] <= THETA_W'(round_shift(s2_hlat_ff, HALF_SHIFT));
         s3_theta_ff[1] <= THETA_W'(round_shift(64'(s2_hlon_ff), HALF_SHIFT));
         s3_theta_ff[2] <= THETA_W'(round_shift(64'(s2_rlat1_ff), RAD_SHIFT));
         s3_theta_ff[3] <= THETA_W'(round_shift(64'(s2_rlat2_ff), RAD_SHIFT));

         for (int l = 0; l < 4; l++) begin
            s4_abs_ff[l]  <= s4_abs_in[l];
            s4_neg_ff[l]  <= s3_theta_ff[l][THETA_W-1];
            s4_q_ff[l]    <= s4_q_in[l];
            s5_rem_ff[l]  <= CORDIC_W'(s4_abs_ff[l]
                                       - THETA_W'(s4_q_ff[l]) * THETA_W'(TWO_PI_U));
            s5_neg_ff[l]  <= s4_neg_ff[l];
            s6_t_ff[l]    <= s6_t_in[l];
            s7_t_ff[l]    <= s7_t_in[l];
            s7_flip_ff[l] <= s7_flip_in[l];
         end
      end
   end

   // ---------------------------------------------------------------- sin / cos
   cordic_ctl_type  rot_ctl [0:3];
   cordic_word_type rot_x   [0:3];
   cordic_word_type rot_y   [0:3];

   genvar g;
   for (g = 0; g < 4; g++) begin : g_rot
      cordic_ctl_type ctl;
      assign ctl.valid = s7_valid_ff;
      assign ctl.flip  = s7_flip_ff[g];

      hvd_cordic #(
         .ITERATIONS (TRIG_ITERATIONS),
         .VECTORING  (1'b0)
      ) u_rot (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .in_ctl  (ctl),
         .in_x    (GAIN_C),
         .in_y    ('0),
         .in_z    (s7_t_ff[g]),
         .out_ctl (rot_ctl[g]),
         .out_x   (rot_x[g]),
         .out_y   (rot_y[g]),
         .out_z   ()
      );
   end

   // ---------------------------------------------------------------- haversine term
   // squares ignore the sign flip; the cosine product takes both flips
   logic                        m1_valid_ff;
   logic signed [2*CORDIC_W-1:0] m1_sq0_ff, m1_sq1_ff, m1_cc_ff;
   logic                        m1_flip_ff;
   logic                        m2_valid_ff;
   cordic_word_type             m2_s1sq_ff, m2_s2sq_ff, m2_cc_ff;
   logic                        m3_valid_ff;
   logic signed [2*CORDIC_W-1:0] m3_prod_ff;
   cordic_word_type             m3_s1sq_ff;
   logic                        m4_valid_ff;
   logic signed [CORDIC_W:0]    m4_sum_ff;
   logic                        m5_valid_ff;
   logic        [61:0]          m5_rad_ff [0:1];
   logic        [30:0]          m5_a;

   always_comb begin
      if (m4_sum_ff < 0) begin
         m5_a = '0;
      end else if (m4_sum_ff > ONE_C) begin
         m5_a = 31'(ONE_C);
      end else begin
         m5_a = m4_sum_ff[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
         m4_valid_ff <= 1'b0;
         m5_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff <= rot_ctl[0].valid;
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
         m4_valid_ff <= m3_valid_ff;
         m5_valid_ff <= m4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_sq0_ff  <= rot_y[0] * rot_y[0];
         m1_sq1_ff  <= rot_y[1] * rot_y[1];
         m1_cc_ff   <= rot_x[2] * rot_x[3];
         m1_flip_ff <= rot_ctl[2].flip ^ rot_ctl[3].flip;

         m2_s1sq_ff <= CORDIC_W'(round_shift(64'(m1_sq0_ff), 30));
         m2_s2sq_ff <= CORDIC_W'(round_shift(64'(m1_sq1_ff), 30));
         m2_cc_ff   <= m1_flip_ff ? -CORDIC_W'(round_shift(64'(m1_cc_ff), 30))
                                  : CORDIC_W'(round_shift(64'(m1_cc_ff), 30));

         m3_prod_ff <= m2_cc_ff * m2_s2sq_ff;
         m3_s1sq_ff <= m2_s1sq_ff;

         m4_sum_ff  <= (CORDIC_W+1)'(round_shift(64'(m3_prod_ff), 30))
                     + (CORDIC_W+1)'(m3_s1sq_ff);

         m5_rad_ff[0] <= {1'b0, m5_a, 30'd0};
         m5_rad_ff[1] <= {1'b0, 31'(ONE_C) - m5_a, 30'd0};
      end
   end

   // ---------------------------------------------------------------- square roots
   // stage j settles result bit 30-j of floor(sqrt(v)) for both lanes
   logic        sq_valid_ff [0:SQRT_STEPS-1];
   logic [61:0] sqv_ff      [0:1][0:SQRT_STEPS-1];
   logic [61:0] sqr_ff      [0:1][0:SQRT_STEPS-1];

   genvar j;
   for (j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam logic [61:0] BIT = 62'd1 << (2 * (SQRT_STEPS - 1 - j));
      logic        valid_cur;
      logic [61:0] v_cur [0:1];
      logic [61:0] r_cur [0:1];
      logic [61:0] v_in  [0:1];
      logic [61:0] r_in  [0:1];

      if (j == 0) begin : g_head
         assign valid_cur = m5_valid_ff;
         assign v_cur     = m5_rad_ff;
         assign r_cur     = '{default: '0};
      end else begin : g_link
         assign valid_cur = sq_valid_ff[j-1];
         assign v_cur     = '{sqv_ff[0][j-1], sqv_ff[1][j-1]};
         assign r_cur     = '{sqr_ff[0][j-1], sqr_ff[1][j-1]};
      end

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            if (v_cur[l] >= r_cur[l] + BIT) begin
               v_in[l] = v_cur[l] - (r_cur[l] + BIT);
               r_in[l] = (r_cur[l] >> 1) + BIT;
            end else begin
               v_in[l] = v_cur[l];
               r_in[l] = r_cur[l] >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[j] <= 1'b0;
         end else if (advance) begin
            sq_valid_ff[j] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            sqv_ff[0][j] <= v_in[0];
            sqr_ff[0][j] <= r_in[0];
            sqv_ff[1][j] <= v_in[1];
            sqr_ff[1][j] <= r_in[1];
         end
      end
   end

   // ---------------------------------------------------------------- atan2
   cordic_ctl_type  vec_in_ctl, vec_ctl;
   cordic_word_type vec_z;

   assign vec_in_ctl.valid = sq_valid_ff[SQRT_STEPS-1];
   assign vec_in_ctl.flip  = 1'b0;

   hvd_cordic #(
      .ITERATIONS (TRIG_ITERATIONS),
      .VECTORING  (1'b1)
   ) u_vec (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_ctl  (vec_in_ctl),
      .in_x    ($signed({3'b000, sqr_ff[1][SQRT_STEPS-1][30:0]})),
      .in_y    ($signed({3'b000, sqr_ff[0][SQRT_STEPS-1][30:0]})),
      .in_z    ('0),
      .out_ctl (vec_ctl),
      .out_x   (),
      .out_y   (),
      .out_z   (vec_z)
   );

   // ---------------------------------------------------------------- scale by radius
   logic                      a1_valid_ff;
   logic [CORDIC_W-1:0]       a1_ang_ff;
   logic                      a2_valid_ff;
   logic [RAD_W+CORDIC_W-1:0] a2_prod_ff;
   logic [RAD_W+CORDIC_W-1:0] a3_round;
   logic [RAD_W+CORDIC_W-31:0] a3_dist;
   logic                      fin_valid_ff;
   logic [DIST_W-1:0]         fin_dist_ff;

   assign a3_round = a2_prod_ff + (RAD_W+CORDIC_W)'(64'd1 << 29);
   assign a3_dist  = a3_round[RAD_W+CORDIC_W-1:30];

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_valid_ff  <= 1'b0;
         a2_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else if (advance) begin
         a1_valid_ff  <= vec_ctl.valid;
         a2_valid_ff  <= a1_valid_ff;
         fin_valid_ff <= a2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // double the half angle; drop a small negative residue to zero
         a1_ang_ff   <= (vec_z < 0) ? '0 : {vec_z[CORDIC_W-2:0], 1'b0};
         a2_prod_ff  <= sphere_radius_ff * a1_ang_ff;
         fin_dist_ff <= (a3_dist[RAD_W+CORDIC_W-31:DIST_W] != '0) ? '1
                                                                   : a3_dist[DIST_W-1:0];
      end
   end

   // ---------------------------------------------------------------- output buffer
   logic              out_valid_ff;
   logic [DIST_W-1:0] out_dist_ff;
   logic [DIST_W-1:0] skid_dist_ff;
   logic              pop;
   logic              incoming;

   assign pop      = out_valid_ff && rsp_ready;
   assign incoming = advance && fin_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // pipeline is held; drain the skid entry first
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (incoming) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_dist_ff <= skid_dist_ff;
         end
      end else if (incoming) begin
         if (out_valid_ff && !pop) begin
            skid_dist_ff <= fin_dist_ff;
         end else begin
            out_dist_ff <= fin_dist_ff;
         end
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_distance_meters = out_dist_ff;

   // ---------------------------------------------------------------- checks
   `ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid item with empty output register")
   `ASSERT_IMPLY(a_skid_fill_on_stall, clock, reset, $rose(skid_valid_ff), $past(out_valid_ff && !rsp_ready), "skid filled without an output stall")
   `ASSERT_NEXT(a_last_stage_held, clock, reset, fin_valid_ff && !advance, fin_valid_ff && $stable(fin_dist_ff), "held last stage item changed")

endmodule

[hdl/hvd_cordic.sv]
// Pipelined CORDIC, one register stage per iteration, rotation or vectoring.
// Depends on hvd_pkg for the word type, control struct and arctangent table.
module hvd_cordic #(
   parameter int ITERATIONS = 24,
   parameter bit VECTORING  = 1'b0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  hvd_pkg::cordic_ctl_type in_ctl,
   input  hvd_pkg::cordic_word_type in_x,
   input  hvd_pkg::cordic_word_type in_y,
   input  hvd_pkg::cordic_word_type in_z,
   output hvd_pkg::cordic_ctl_type out_ctl,
   output hvd_pkg::cordic_word_type out_x,
   output hvd_pkg::cordic_word_type out_y,
   output hvd_pkg::cordic_word_type out_z
);
   import hvd_pkg::*;

   cordic_ctl_type  ctl_ff [0:ITERATIONS-1];
   cordic_word_type x_ff   [0:ITERATIONS-1];
   cordic_word_type y_ff   [0:ITERATIONS-1];
   cordic_word_type z_ff   [0:ITERATIONS-1];

   genvar i;
   for (i = 0; i < ITERATIONS; i++) begin : g_stage
      localparam cordic_word_type ANGLE = atan_entry(i);
      cordic_ctl_type  ctl_cur;
      cordic_word_type x_cur, y_cur, z_cur;
      cordic_word_type x_in, y_in, z_in;
      logic            rot;

      if (i == 0) begin : g_head
         assign ctl_cur = in_ctl;
         assign x_cur   = in_x;
         assign y_cur   = in_y;
         assign z_cur   = in_z;
      end else begin : g_link
         assign ctl_cur = ctl_ff[i-1];
         assign x_cur   = x_ff[i-1];
         assign y_cur   = y_ff[i-1];
         assign z_cur   = z_ff[i-1];
      end

      // rotation steers by the residual angle, vectoring drives y to zero
      assign rot  = VECTORING ? !(y_cur > 0) : (z_cur >= 0);
      assign x_in = rot ? x_cur - (y_cur >>> i) : x_cur + (y_cur >>> i);
      assign y_in = rot ? y_cur + (x_cur >>> i) : y_cur - (x_cur >>> i);
      assign z_in = rot ? z_cur - ANGLE : z_cur + ANGLE;

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i] <= '0;
         end else if (advance) begin
            ctl_ff[i] <= ctl_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   assign out_ctl = ctl_ff[ITERATIONS-1];
   assign out_x   = x_ff[ITERATIONS-1];
   assign out_y   = y_ff[ITERATIONS-1];
   assign out_z   = z_ff[ITERATIONS-1];

endmodule
